/* sv/bud_pkg.sv */
// Package for the buddy allocator: sizes, opcodes, status codes and the sequencer state type.
// No dependencies.
package bud_pkg;
  localparam int unsigned PoolOrderDef = 16;
  localparam int unsigned MinOrderDef  = 5;
  localparam int unsigned HdrReset     = 24;

  localparam logic OpAlloc = 1'b0;
  localparam logic OpFree  = 1'b1;

  localparam logic StOk   = 1'b0;
  localparam logic StFail = 1'b1;

  typedef enum logic [4:0] {
    S_IDLE, S_A_SCAN, S_A_POP_RD, S_A_POP_WT, S_A_POP_NX, S_A_SPLIT,
    S_A_SPLIT_WR, S_A_DONE,
    S_F_RD, S_F_WT, S_F_CHK, S_F_BUD_RD, S_F_BUD_WT, S_F_BUD_CHK,
    S_F_UL_P_RD, S_F_UL_P_WT, S_F_UL_N_RD, S_F_UL_N_WT, S_F_PUSH_RD,
    S_F_PUSH_WT, S_F_PUSH_WR, S_OUT, S_CLEAR
  } state_e;
endpackage

/* sv/buddy_allocator.sv */
// Buddy allocator top level: control sequencer, list heads, header register.
// Depends on bud_pkg and bud_mem.
//
//  channel | dir | fields
//  s_axis  | in  | tdata: opcode, request_size, user_offset
//  m_axis  | out | tdata: status, result_offset, block_order
//  cfg     | in  | header_bytes
//
// An allocate scans the lists upward from the request order, pops the first block
// and splits it down (one scan step and two split steps per level above that order).
// A free checks the unit record, merges it with its free buddy level by level, then pushes it.
// After reset a clearing pass writes every unit record while s_axis_tready stays
// low. The result register holds while m_axis_tready is low; a finished item
// waits in S_OUT until it is free.
module buddy_allocator
  import bud_pkg::*;
#(
  parameter int unsigned PoolOrder = PoolOrderDef,
  parameter int unsigned MinOrder  = MinOrderDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // opcode, request_size[19:0], user_offset[15:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // status, result_offset[15:0], block_order[4:0]
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i
);
  localparam int unsigned UW = PoolOrder - MinOrder;
  localparam int unsigned NU = 1 << UW;
  localparam int unsigned LW = UW + 1;         // link incl. NIL
  localparam int unsigned RW = 2 * LW + 5 + 2; // next, prev, order, free, used
  localparam logic [LW-1:0] Nil = LW'(NU);

  typedef struct packed {
    logic [LW-1:0] nxt;
    logic [LW-1:0] prv;
    logic [4:0]    ord;
    logic          fr;
    logic          used;
  } rec_t;

  logic [7:0] hdr_q;
  logic [LW-1:0] heads_q [PoolOrder+1];
  state_e st_q, st_d;

  logic [UW-1:0] u_q, b_q, clr_q;
  logic [4:0] k_q, j_q, o_q;
  logic [19:0] size_q;
  logic [15:0] uoff_q;
  rec_t cur_q, bud_q;
  logic [23:0] res_q;
  logic [23:0] out_q;
  logic ovld_q;
  logic out_free;

  logic we;
  logic [UW-1:0] wa, ra;
  rec_t wd, rd;
  logic [RW-1:0] rdv;
  assign rd = rec_t'(rdv);

  bud_mem #(.Depth(NU), .Width(RW)) u_mem (
    .clk_i, .we_i(we), .waddr_i(wa), .wdata_i(RW'(wd)), .raddr_i(ra), .rdata_o(rdv)
  );

  // request order
  logic [20:0] need;
  logic [4:0] kcalc;
  logic too_big;
  assign need = {1'b0, size_q} + 21'(hdr_q);
  always_comb begin
    kcalc = 5'd0;
    for (int i = 20; i >= 0; i--) begin
      if (need > (21'd1 << i)) begin
        if (kcalc == 5'd0) kcalc = 5'(i + 1);
      end
    end
    if (kcalc < 5'(MinOrder)) kcalc = 5'(MinOrder);
    too_big = kcalc > 5'(PoolOrder);
  end

  logic [31:0] start;
  assign start = 32'(uoff_q) - 32'(hdr_q);
  logic free_bad;
  assign free_bad = (uoff_q < 16'(hdr_q)) || (start >= (32'd1 << PoolOrder))
                    || (start[MinOrder-1:0] != '0);
  logic [UW-1:0] half;
  assign half = UW'(1) << (j_q - 5'd1 - 5'(MinOrder));
  logic [UW-1:0] bmask;
  assign bmask = UW'(1) << (o_q - 5'(MinOrder));
  logic [15:0] aoff;
  assign aoff = 16'({u_q, {MinOrder{1'b0}}}) + 16'(hdr_q);

  logic [4:0] jclip;
  assign jclip = (j_q > 5'(PoolOrder)) ? 5'd0 : j_q;
  logic [LW-1:0] hj;
  assign hj = heads_q[jclip];

  assign out_free = !ovld_q || m_axis_tready;
  assign s_axis_tready = (st_q == S_IDLE);
  assign m_axis_tvalid = ovld_q;
  assign m_axis_tdata  = out_q;

  always_comb begin
    st_d = st_q;
    case (st_q)
      S_CLEAR:      if (clr_q == UW'(NU - 1)) st_d = S_IDLE;
      S_IDLE:       if (s_axis_tvalid && s_axis_tready) st_d =
                      (s_axis_tdata[0] == OpAlloc) ? S_A_SCAN : S_F_RD;
      S_A_SCAN:     if (size_q == '0 || too_big || j_q > 5'(PoolOrder)) st_d = S_OUT;
                    else if (hj != Nil) st_d = S_A_POP_RD;
      S_A_POP_RD:   st_d = S_A_POP_WT;
      S_A_POP_WT:   st_d = S_A_POP_NX;
      S_A_POP_NX:   st_d = S_A_SPLIT;
      S_A_SPLIT:    st_d = (j_q > k_q) ? S_A_SPLIT_WR : S_A_DONE;
      S_A_SPLIT_WR: st_d = S_A_SPLIT;
      S_A_DONE:     st_d = S_OUT;
      S_F_RD:       st_d = free_bad ? S_OUT : S_F_WT;
      S_F_WT:       st_d = S_F_CHK;
      S_F_CHK:      st_d = (!cur_q.used || cur_q.ord < 5'(MinOrder) ||
                            cur_q.ord > 5'(PoolOrder)) ? S_OUT : S_F_BUD_RD;
      S_F_BUD_RD:   st_d = (o_q >= 5'(PoolOrder)) ? S_F_PUSH_RD : S_F_BUD_WT;
      S_F_BUD_WT:   st_d = S_F_BUD_CHK;
      S_F_BUD_CHK:  st_d = (!bud_q.fr || bud_q.ord != o_q) ? S_F_PUSH_RD : S_F_UL_P_RD;
      S_F_UL_P_RD:  st_d = S_F_UL_P_WT;
      S_F_UL_P_WT:  st_d = S_F_UL_N_RD;
      S_F_UL_N_RD:  st_d = S_F_UL_N_WT;
      S_F_UL_N_WT:  st_d = S_F_BUD_RD;
      S_F_PUSH_RD:  st_d = S_F_PUSH_WT;
      S_F_PUSH_WT:  st_d = S_F_PUSH_WR;
      S_F_PUSH_WR:  st_d = S_OUT;
      S_OUT:        if (out_free) st_d = S_IDLE;
      default:      st_d = S_IDLE;
    endcase
  end

  // memory port control; reads land in rd in the next cycle
  always_comb begin
    we = 1'b0;
    wa = u_q;
    wd = cur_q;
    ra = u_q;
    case (st_q)
      S_CLEAR: begin
        we = 1'b1;
        wa = clr_q;
        wd = '{nxt: Nil, prv: Nil, ord: (clr_q == '0) ? 5'(PoolOrder) : 5'd0,
               fr: (clr_q == '0), used: 1'b0};
      end
      S_A_POP_RD: ra = hj[UW-1:0];
      S_A_POP_WT: ra = rd.nxt[UW-1:0];
      S_A_POP_NX: if (cur_q.nxt != Nil) begin
        we = 1'b1;
        wa = cur_q.nxt[UW-1:0];
        wd = rd;
        wd.prv = Nil;
      end
      // lists from the request order up to below the popped order are empty, so the upper half is alone
      S_A_SPLIT_WR: begin
        we = 1'b1;
        wa = u_q + half;
        wd = '{nxt: Nil, prv: Nil, ord: j_q - 5'd1, fr: 1'b1, used: 1'b0};
      end
      S_A_DONE: begin
        we = 1'b1;
        wa = u_q;
        wd = '{nxt: Nil, prv: Nil, ord: k_q, fr: 1'b0, used: 1'b1};
      end
      S_F_RD: ra = start[MinOrder +: UW];
      S_F_CHK: if (st_d == S_F_BUD_RD) begin
        we = 1'b1;
        wa = u_q;
        wd = cur_q;
        wd.used = 1'b0;
      end
      S_F_BUD_RD: ra = u_q ^ bmask;
      S_F_UL_P_RD: begin
        ra = bud_q.prv[UW-1:0];
        we = 1'b1;
        wa = b_q;
        wd = '{nxt: Nil, prv: Nil, ord: bud_q.ord, fr: 1'b0, used: bud_q.used};
      end
      S_F_UL_P_WT: begin
        ra = bud_q.nxt[UW-1:0];
        if (bud_q.prv != Nil) begin
          we = 1'b1;
          wa = bud_q.prv[UW-1:0];
          wd = rd;
          wd.nxt = bud_q.nxt;
        end
      end
      S_F_UL_N_RD: ra = bud_q.nxt[UW-1:0];
      S_F_UL_N_WT: if (bud_q.nxt != Nil) begin
        we = 1'b1;
        wa = bud_q.nxt[UW-1:0];
        wd = rd;
        wd.prv = bud_q.prv;
      end
      S_F_PUSH_RD: ra = heads_q[o_q][UW-1:0];
      S_F_PUSH_WT: if (heads_q[o_q] != Nil) begin
        we = 1'b1;
        wa = heads_q[o_q][UW-1:0];
        wd = rd;
        wd.prv = LW'(u_q);
      end
      S_F_PUSH_WR: begin
        we = 1'b1;
        wa = u_q;
        wd = '{nxt: heads_q[o_q], prv: Nil, ord: o_q, fr: 1'b1, used: 1'b0};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_CLEAR;
      clr_q <= '0;
      hdr_q <= 8'(HdrReset);
      ovld_q <= 1'b0;
      out_q <= '0;
      for (int unsigned i = 0; i <= PoolOrder; i++)
        heads_q[i] <= (i == PoolOrder) ? LW'(0) : Nil;
    end else begin
      st_q <= st_d;
      if (cfg_we_i) hdr_q <= cfg_wdata_i;
      if (st_q == S_OUT && out_free) begin
        ovld_q <= 1'b1;
        out_q <= res_q;
      end else if (m_axis_tready) begin
        ovld_q <= 1'b0;
      end
      case (st_q)
        S_CLEAR: clr_q <= clr_q + UW'(1);
        S_IDLE: if (s_axis_tvalid && s_axis_tready) begin
          size_q <= s_axis_tdata[20:1];
          uoff_q <= s_axis_tdata[36:21];
          res_q <= {5'd0, 16'd0, 2'b0, StFail};
          j_q <= '0;
        end
        S_A_SCAN: begin
          k_q <= kcalc;
          if (j_q == '0) j_q <= kcalc;
          else if (hj == Nil) j_q <= j_q + 5'd1;
        end
        S_A_POP_RD: u_q <= hj[UW-1:0];
        S_A_POP_WT: begin
          cur_q <= rd;
          heads_q[j_q] <= rd.nxt;
        end
        S_A_SPLIT_WR: begin
          heads_q[j_q - 5'd1] <= LW'(u_q + half);
          j_q <= j_q - 5'd1;
        end
        S_A_DONE:
          res_q <= {2'b0, k_q, aoff, StOk};
        S_F_RD: begin
          u_q <= start[MinOrder +: UW];
        end
        S_F_WT: cur_q <= rd;
        S_F_CHK: o_q <= cur_q.ord;
        S_F_BUD_RD: b_q <= u_q ^ bmask;
        S_F_BUD_WT: bud_q <= rd;
        S_F_UL_P_RD: if (heads_q[o_q] == LW'(b_q)) heads_q[o_q] <= bud_q.nxt;
        S_F_UL_N_WT: begin
          if (b_q < u_q) u_q <= b_q;
          o_q <= o_q + 5'd1;
        end
        S_F_PUSH_WR: begin
          heads_q[o_q] <= LW'(u_q);
          res_q <= {2'b0, o_q, 16'd0, StOk};
        end
        default: ;
      endcase
    end
  end
endmodule

/* sv/bud_mem.sv */
// Unit header memory: one synchronous-read RAM of packed unit records.
// Depends on nothing; record width set by the instantiating module.
module bud_mem #(
  parameter int unsigned Depth = 2048,
  parameter int unsigned Width = 31
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule
